FILE: src/fsum_pkg.sv
`default_nettype none
package fsum_pkg;

    // packet layout, in bytes
    localparam int PRIMARY_HEADER_BYTES = 10;
    localparam int TRAILER_BYTES        = 4;
    localparam int SYNC_BYTES           = 4;
    localparam int FULL_HEADER_BYTES    = 11;
    localparam int LEN_HI_INDEX         = 8;
    localparam int LEN_LO_INDEX         = 9;
    // last input byte sits at length + LAST_OFFSET
    localparam int LAST_OFFSET          = FULL_HEADER_BYTES - TRAILER_BYTES - 1;

    localparam int IDX_W    = 17;
    localparam int LEN_W    = 16;
    localparam int MOD_BASE = 255;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        JOB_PASS,
        JOB_ERROR,
        JOB_TRAILER
    } job_kind_t;

    // one classified input byte, with the running sums when a trailer follows
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;
        logic [7:0]  simple_sum;
        logic [7:0]  fletcher_sum;
        logic [15:0] word_sum;
    } job_t;

    // queue handshake seen by one side
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef enum logic [2:0] {
        PH_DATA,
        PH_SIMPLE,
        PH_FLETCHER,
        PH_WORD_HI,
        PH_WORD_LO
    } phase_t;

    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= 9'(MOD_BASE))
                s = s - 9'(MOD_BASE);
            return s[7:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/fsum_front.sv
`default_nettype none
module fsum_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   first_of_packet,
    input  wire fsum_pkg::queue_status_t q_status,
    output logic                        push,
    output fsum_pkg::job_t              push_job
);
    import fsum_pkg::*;

    logic             in_packet_reg, in_packet_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       simple_reg, simple_next;
    logic [7:0]       fletcher_reg, fletcher_next;
    logic [15:0]      word_reg, word_next;

    logic             take;
    logic [IDX_W-1:0] idx_c;
    logic [7:0]       simple_c, fletcher_c;
    logic [15:0]      word_c;
    logic [LEN_W-1:0] len_c;
    logic             len_short, pkt_end;

    assign in_stall = q_status.full;
    assign take     = in_valid && !in_stall;

    // a start flag restarts the packet state
    always_comb
    begin
        idx_c      = first_of_packet ? '0 : idx_reg;
        simple_c   = first_of_packet ? '0 : simple_reg;
        fletcher_c = first_of_packet ? '0 : fletcher_reg;
        word_c     = first_of_packet ? '0 : word_reg;
        len_c      = first_of_packet ? '0 : len_reg;
    end

    // length capture, sums and packet end detection
    always_comb
    begin
        len_next = len_c;
        if (idx_c == IDX_W'(LEN_HI_INDEX))
            len_next = {data_byte, len_c[7:0]};
        if (idx_c == IDX_W'(LEN_LO_INDEX))
            len_next = {len_c[15:8], data_byte};

        simple_next   = simple_c;
        fletcher_next = fletcher_c;
        if (idx_c >= IDX_W'(PRIMARY_HEADER_BYTES))
        begin
            simple_next   = add_mod255(simple_c, data_byte);
            fletcher_next = add_mod255(fletcher_c, simple_next);
        end

        word_next = word_c;
        if (idx_c >= IDX_W'(SYNC_BYTES))
            word_next = word_c + {8'd0, data_byte};

        len_short = (idx_c == IDX_W'(LEN_LO_INDEX)) && (len_next < LEN_W'(TRAILER_BYTES));
        pkt_end   = (idx_c > IDX_W'(LEN_LO_INDEX))
                    && (idx_c == ({1'b0, len_next} + IDX_W'(LAST_OFFSET)));

        in_packet_next = 1'b1;
        idx_next       = idx_c + 1'b1;
        if (len_short || pkt_end)
        begin
            in_packet_next = 1'b0;
            idx_next       = '0;
        end
    end

    // job into the queue
    always_comb
    begin
        push                  = take && (first_of_packet || in_packet_reg);
        push_job.data         = data_byte;
        push_job.simple_sum   = simple_next;
        push_job.fletcher_sum = fletcher_next;
        push_job.word_sum     = word_next;
        priority if (len_short)
            push_job.kind = JOB_ERROR;
        else if (pkt_end)
            push_job.kind = JOB_TRAILER;
        else
            push_job.kind = JOB_PASS;
    end

    // packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            idx_reg       <= '0;
            len_reg       <= '0;
            simple_reg    <= '0;
            fletcher_reg  <= '0;
            word_reg      <= '0;
        end
        else if (push)
        begin
            in_packet_reg <= in_packet_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            simple_reg    <= simple_next;
            fletcher_reg  <= fletcher_next;
            word_reg      <= word_next;
        end
    end

    // a closed packet stays closed until the next start flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && (push_job.kind == JOB_ERROR || push_job.kind == JOB_TRAILER))
        |=> !in_packet_reg)
        else $error("packet still open after its end");

endmodule
`default_nettype wire

FILE: src/fsum_queue.sv
`default_nettype none
module fsum_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire fsum_pkg::job_t         push_job,
    input  wire logic                   pop,
    output fsum_pkg::job_t              head_job,
    output fsum_pkg::queue_status_t     status
);
    import fsum_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_job     = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    // the front never offers a job into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(push && status.full))
        else $error("push into full queue");

endmodule
`default_nettype wire

FILE: src/fsum_back.sv
`default_nettype none
module fsum_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fsum_pkg::job_t         head_job,
    input  wire fsum_pkg::queue_status_t q_status,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  out_byte,
    output logic                        is_trailer,
    output logic                        last_of_packet,
    output logic                        length_error
);
    import fsum_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] word_reg, word_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        trailer_reg, trailer_next;
    logic        last_reg, last_next;
    logic        err_reg, err_next;
    logic        load;

    assign load           = !valid_reg || !out_stall;
    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign is_trailer     = trailer_reg;
    assign last_of_packet = last_reg;
    assign length_error   = err_reg;

    // phase sequencer and next output byte
    always_comb
    begin
        phase_next   = phase_reg;
        word_next    = word_reg;
        pop          = 1'b0;
        valid_next   = valid_reg && out_stall;
        byte_next    = byte_reg;
        trailer_next = trailer_reg;
        last_next    = last_reg;
        err_next     = err_reg;
        if (load && !q_status.empty)
        begin
            valid_next   = 1'b1;
            trailer_next = 1'b1;
            last_next    = 1'b0;
            err_next     = 1'b0;
            unique case (phase_reg)
                PH_DATA:
                begin
                    byte_next    = head_job.data;
                    trailer_next = 1'b0;
                    last_next    = (head_job.kind == JOB_ERROR);
                    err_next     = (head_job.kind == JOB_ERROR);
                    if (head_job.kind == JOB_TRAILER)
                        phase_next = PH_SIMPLE;
                    else
                        pop = 1'b1;
                end
                PH_SIMPLE:
                begin
                    byte_next  = head_job.simple_sum;
                    word_next  = head_job.word_sum + {8'd0, head_job.simple_sum}
                                 + {8'd0, head_job.fletcher_sum};
                    phase_next = PH_FLETCHER;
                end
                PH_FLETCHER:
                begin
                    byte_next  = head_job.fletcher_sum;
                    phase_next = PH_WORD_HI;
                end
                PH_WORD_HI:
                begin
                    byte_next  = word_reg[15:8];
                    phase_next = PH_WORD_LO;
                end
                PH_WORD_LO:
                begin
                    byte_next  = word_reg[7:0];
                    last_next  = 1'b1;
                    phase_next = PH_DATA;
                    pop        = 1'b1;
                end
                default:
                begin
                    phase_next = PH_DATA;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // output payload and trailer word
    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        byte_reg    <= byte_next;
        trailer_reg <= trailer_next;
        last_reg    <= last_next;
        err_reg     <= err_next;
    end

    // a job leaves the queue only at its final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (phase_reg == PH_DATA || phase_reg == PH_WORD_LO))
        else $error("job popped mid trailer");

    // an error byte always closes the packet and is never a trailer byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && err_reg) |-> (last_reg && !trailer_reg))
        else $error("bad error byte flags");

endmodule
`default_nettype wire

FILE: src/packet_fletcher_sum_trailer.sv
`default_nettype none
// Packet checksum trailer: passes each byte of a packet through (the start flag marks the
// sync byte), reads the 16-bit length from bytes 8 and 9, and after the last payload byte
// appends four trailer bytes: the mod-255 simple sum and Fletcher sum taken from byte 10 on,
// then the high and low byte of a 16-bit wrapping sum taken from the sync offset on that also
// adds in both mod-255 sums; the low byte carries last_of_packet. A length below four ends
// the packet on byte 9 with length_error and last_of_packet set and no trailer. Bytes before
// a start flag are dropped. The front classifies and sums one input byte per cycle while the
// four-entry job queue has room, and a byte passes through a queue entry and then the output
// register on its way out. The output side delivers one byte per cycle while out_stall is low
// and jobs are queued, so a packet of N input bytes with a trailer gives N + 4 output bytes.
// While the byte sequencer walks the four trailer phases it takes no new job, so with packets
// back to back the input can be stalled once the queue's spare entries are used; in_stall
// follows a full queue only, so it also stays high in the cycle the full queue pops. No
// clearing pass after reset.
module packet_fletcher_sum_trailer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       first_of_packet,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            is_trailer,
    output logic            last_of_packet,
    output logic            length_error
);
    import fsum_pkg::*;

    queue_status_t q_status;
    job_t          push_job, head_job;
    logic          push, pop;

    // classify and sum incoming bytes
    fsum_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .first_of_packet (first_of_packet),
        .q_status        (q_status),
        .push            (push),
        .push_job        (push_job)
    );

    // jobs between front and back
    fsum_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // emit passed bytes and trailers
    fsum_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_job       (head_job),
        .q_status       (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_trailer     (is_trailer),
        .last_of_packet (last_of_packet),
        .length_error   (length_error)
    );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsum_pkg::*;

    localparam int RANDOM_ITEMS   = 290;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 32;

    // how a stream byte is checked: typed-in result, none, or the predictor
    typedef enum logic [1:0] {
        ROW_PREDICTED,
        ROW_DROPPED,
        ROW_PASS,
        ROW_LEN_ERROR
    } row_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        row_kind_t  kind;
    } stream_row_t;

    typedef struct packed {
        logic [7:0] value;
        logic       trailer;
        logic       last;
        logic       err;
    } out_byte_t;

    // directed stimulus
    localparam stream_row_t DIRECTED [25] = '{
        // stray bytes right after reset are dropped
        '{8'hFF, 1'b0, ROW_DROPPED},
        '{8'h00, 1'b0, ROW_DROPPED},
        // packet abandoned by a new start
        '{8'h5A, 1'b1, ROW_PASS},
        '{8'hC3, 1'b0, ROW_PASS},
        // zero length field ends the packet on byte 9
        '{8'hFF, 1'b1, ROW_PASS},
        '{8'h01, 1'b0, ROW_PASS},
        '{8'h02, 1'b0, ROW_PASS},
        '{8'h03, 1'b0, ROW_PASS},
        '{8'h80, 1'b0, ROW_PASS},
        '{8'h7F, 1'b0, ROW_PASS},
        '{8'hAA, 1'b0, ROW_PASS},
        '{8'h55, 1'b0, ROW_PASS},
        '{8'h00, 1'b0, ROW_PASS},
        '{8'h00, 1'b0, ROW_LEN_ERROR},
        // shortest legal packet, 0xFF bytes wrap the mod-255 sums
        '{8'h00, 1'b1, ROW_PASS},
        '{8'hFF, 1'b0, ROW_PASS},
        '{8'hFF, 1'b0, ROW_PASS},
        '{8'hFF, 1'b0, ROW_PASS},
        '{8'hFF, 1'b0, ROW_PASS},
        '{8'h00, 1'b0, ROW_PASS},
        '{8'hFF, 1'b0, ROW_PASS},
        '{8'h01, 1'b0, ROW_PASS},
        '{8'h00, 1'b0, ROW_PASS},
        '{8'h04, 1'b0, ROW_PASS},
        '{8'hFF, 1'b0, ROW_PREDICTED}
    };

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       in_valid        = 1'b0;
    logic [7:0] data_byte       = 8'h00;
    logic       first_of_packet = 1'b0;
    logic       out_stall       = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       is_trailer;
    logic       last_of_packet;
    logic       length_error;

    stream_row_t packet_stream [$];
    out_byte_t   expected_bytes [$];

    // predictor state
    logic        pkt_open;
    logic [16:0] pkt_index;
    logic [15:0] pkt_len;
    logic [7:0]  simple_acc;
    logic [7:0]  fletcher_acc;
    logic [15:0] word_acc;

    int send_ptr     = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_tick   = 0;
    int stall_mode   = 0;
    int idle_cycles  = 0;
    int failures     = 0;
    int in_count     = 0;
    int out_count    = 0;
    int trailer_seen = 0;
    int len_err_seen = 0;

    packet_fletcher_sum_trailer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .first_of_packet(first_of_packet),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_trailer     (is_trailer),
        .last_of_packet (last_of_packet),
        .length_error   (length_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] fold255_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 9'd255)
            s = s - 9'd255;
        return s[7:0];
    endfunction

    function automatic void note_byte(input logic [7:0] v, input logic tr, input logic last,
                                      input logic err);
        expected_bytes.push_back('{v, tr, last, err});
    endfunction

    // running sums and packet framing; queues the output bytes when asked
    function automatic void predict_checksum_bytes(input logic [7:0] b, input logic first,
                                                   input bit record);
        int idx;
        if (first)
        begin
            pkt_open     = 1'b1;
            pkt_index    = '0;
            pkt_len      = '0;
            simple_acc   = '0;
            fletcher_acc = '0;
            word_acc     = '0;
        end
        else if (!pkt_open)
            return;
        idx = int'(pkt_index);

        // length field, high byte first
        if (idx == LEN_HI_INDEX)
            pkt_len[15:8] = b;
        if (idx == LEN_LO_INDEX)
            pkt_len[7:0] = b;

        if (idx >= PRIMARY_HEADER_BYTES)
        begin
            simple_acc   = fold255_add(simple_acc, b);
            fletcher_acc = fold255_add(fletcher_acc, simple_acc);
        end
        if (idx >= SYNC_BYTES)
            word_acc = word_acc + 16'(b);

        // short length closes the packet on its low byte
        if (idx == LEN_LO_INDEX && int'(pkt_len) < TRAILER_BYTES)
        begin
            if (record)
                note_byte(b, 1'b0, 1'b1, 1'b1);
            pkt_open  = 1'b0;
            pkt_index = '0;
            return;
        end

        // last payload byte, then the four trailer bytes
        if (idx > LEN_LO_INDEX && idx == int'(pkt_len) + LAST_OFFSET)
        begin
            word_acc = word_acc + 16'(simple_acc);
            word_acc = word_acc + 16'(fletcher_acc);
            if (record)
            begin
                note_byte(b, 1'b0, 1'b0, 1'b0);
                note_byte(simple_acc, 1'b1, 1'b0, 1'b0);
                note_byte(fletcher_acc, 1'b1, 1'b0, 1'b0);
                note_byte(word_acc[15:8], 1'b1, 1'b0, 1'b0);
                note_byte(word_acc[7:0], 1'b1, 1'b1, 1'b0);
            end
            pkt_open  = 1'b0;
            pkt_index = '0;
            return;
        end

        if (record)
            note_byte(b, 1'b0, 1'b0, 1'b0);
        pkt_index = pkt_index + 17'd1;
    endfunction

    // accepted input transfer: typed-in rows override the predictor's output
    function automatic void take_input(input stream_row_t row);
        predict_checksum_bytes(row.data, row.first, row.kind == ROW_PREDICTED);
        case (row.kind)
            ROW_PASS:      note_byte(row.data, 1'b0, 1'b0, 1'b0);
            ROW_LEN_ERROR: note_byte(row.data, 1'b0, 1'b1, 1'b1);
            default: ;
        endcase
        in_count++;
    endfunction

    // accepted output transfer against the oldest expectation
    function automatic void check_output();
        out_byte_t want;
        out_count++;
        if (is_trailer && last_of_packet)
            trailer_seen++;
        if (length_error)
            len_err_seen++;
        if (expected_bytes.size() == 0)
        begin
            $error("unexpected output transfer: out_byte %0h", out_byte);
            failures++;
            return;
        end
        want = expected_bytes.pop_front();
        if (out_byte !== want.value)
        begin
            $error("out_byte: expected %0h, actual %0h", want.value, out_byte);
            failures++;
        end
        if (is_trailer !== want.trailer)
        begin
            $error("is_trailer: expected %0b, actual %0b", want.trailer, is_trailer);
            failures++;
        end
        if (last_of_packet !== want.last)
        begin
            $error("last_of_packet: expected %0b, actual %0b", want.last, last_of_packet);
            failures++;
        end
        if (length_error !== want.err)
        begin
            $error("length_error: expected %0b, actual %0b", want.err, length_error);
            failures++;
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic first);
        packet_stream.push_back('{b, first, ROW_PREDICTED});
    endfunction

    // random packets: mostly well formed, some abandoned, short or stray
    function automatic void build_random_stream();
        int produced;
        int pick;
        int n;
        int len;
        int last_idx;
        logic [7:0] b;
        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                // stray bytes, dropped unless a packet is still open
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    queue_byte(8'($urandom), 1'b0);
            end
            else if (pick < 16)
            begin
                // cut short by the next start, length high byte nonzero
                n = $urandom_range(1, 13);
                for (int k = 0; k < n; k++)
                begin
                    b = 8'($urandom);
                    if (k == LEN_HI_INDEX)
                        b = 8'($urandom_range(1, 255));
                    queue_byte(b, k == 0);
                end
                produced += n;
            end
            else
            begin
                if (pick < 26)
                    len = $urandom_range(0, TRAILER_BYTES - 1);
                else if (pick < 30)
                    len = $urandom_range(25, 90);
                else
                    len = $urandom_range(TRAILER_BYTES, 24);
                last_idx = (len < TRAILER_BYTES) ? LEN_LO_INDEX : len + LAST_OFFSET;
                for (int k = 0; k <= last_idx; k++)
                begin
                    b = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                    if (k == LEN_HI_INDEX)
                        b = 8'(len >> 8);
                    if (k == LEN_LO_INDEX)
                        b = 8'(len);
                    queue_byte(b, k == 0);
                end
                produced += last_idx + 1;
            end
        end
    endfunction

    // sender bursts, receiver stall pattern, scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // input side transfer
            if (in_valid && !in_stall)
            begin
                take_input(packet_stream[send_ptr]);
                send_ptr++;
            end

            if (in_valid && in_stall)
                ;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (send_ptr < packet_stream.size())
            begin
                in_valid        <= 1'b1;
                data_byte       <= packet_stream[send_ptr].data;
                first_of_packet <= packet_stream[send_ptr].first;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;

            // output side transfer
            if (out_valid && !out_stall)
                check_output();

            // receiver stall mode, redrawn at random, picks the out_stall pattern
            if (stall_tick % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                2:       out_stall <= (stall_tick % 3 == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
            stall_tick++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall))
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    initial
    begin
        pkt_open     = 1'b0;
        pkt_index    = '0;
        pkt_len      = '0;
        simple_acc   = '0;
        fletcher_acc = '0;
        word_acc     = '0;

        // directed rows first, then random packets
        foreach (DIRECTED[i])
            packet_stream.push_back(DIRECTED[i]);
        build_random_stream();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (send_ptr < packet_stream.size() || in_valid)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input and %0d output transfers, %0d trailers, %0d length errors",
                 in_count, out_count, trailer_seen, len_err_seen);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/fsum_pkg.sv
src/fsum_front.sv
src/fsum_queue.sv
src/fsum_back.sv
src/packet_fletcher_sum_trailer.sv
tb/testbench.sv
